// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("windowed speed estimator: assertion failed");
`define WSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("windowed speed estimator: assertion failed");
`else
`define WSE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WSE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/wse_pkg.sv =====
package wse_pkg;

  localparam int GAIN_TABLE_ENTRIES = 64;
  localparam int GIDX_W = $clog2(GAIN_TABLE_ENTRIES);

  localparam int POS_W   = 28;
  localparam int FT_W    = 22;
  localparam int SPD_W   = 16;
  localparam int WIN_W   = 20;
  localparam int HITCH_W = 22;
  localparam int JUMP_W  = 20;
  localparam int WDIST_W = 32;
  localparam int WTIME_W = 23;

  localparam int SQ_W    = 2 * POS_W + 2;
  localparam int ROOT_W  = POS_W + 1;
  localparam int REM_W   = ROOT_W + 1;

  localparam int SCALE_W = 20;
  localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
  localparam int NUM_W   = 52;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [WIN_W-1:0]   WINDOW_US_RST = 20'd200000;
  localparam logic [HITCH_W-1:0] HITCH_RST     = 22'd500000;
  localparam logic [JUMP_W-1:0]  JUMP_RST      = 20'd30000;
  localparam logic [SPD_W-1:0]   MOVE_ON_RST   = 16'd1500;
  localparam logic [SPD_W-1:0]   MOVE_OFF_RST  = 16'd600;

  // gain index: round(window_time / 10 ms) by reciprocal multiply
  localparam logic [WTIME_W:0] IDX_HALF  = 24'd5000;
  localparam logic [WTIME_W:0] IDX_LIMIT = 24'((GAIN_TABLE_ENTRIES - 1) * 10000);
  localparam int M_W      = $clog2(GAIN_TABLE_ENTRIES * 625);
  localparam int RECIP_W  = 19;
  localparam int RECIP_SH = 28;
  localparam logic [RECIP_W-1:0] RECIP_M = 19'd429497;

  typedef enum logic [2:0] {
    REG_WINDOW_US,
    REG_HITCH_LIMIT_US,
    REG_JUMP_LIMIT_MM,
    REG_MOVE_ON_MM_S,
    REG_MOVE_OFF_MM_S
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQGO,
    ST_SQ,
    ST_ACC,
    ST_DVGO,
    ST_DV,
    ST_EMA0,
    ST_MUL,
    ST_APPLY,
    ST_FLAG,
    ST_DONE
  } wse_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_ROOT
  } sq_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_SCALE,
    DV_DIV
  } dv_state_t;

  typedef logic [SPD_W-1:0] gain_tab_t [GAIN_TABLE_ENTRIES];

  function automatic gain_tab_t build_gain(logic [63:0] r);
    logic [63:0] d;
    logic [63:0] g;
    gain_tab_t   t;
    d = 64'h1_0000_0000;
    t[0] = '0;
    for (int i = 1; i < GAIN_TABLE_ENTRIES; i++) begin
      d = (d * r + 64'h8000_0000) >> 32;
      g = 64'd65536 - ((d + 64'd32768) >> 16);
      t[i] = (g > 64'd65535) ? 16'hFFFF : g[15:0];
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_SLOW = build_gain(64'd4273546057);
  localparam gain_tab_t GAIN_FAST = build_gain(64'd4188924176);

endpackage

// ===== hw/rtl/wse_chan_if.sv =====
interface wse_frame_if;
  import wse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_z;
  logic [FT_W-1:0]         frame_us;
  modport source (output valid, pos_x, pos_z, frame_us, input ready);
  modport sink (input valid, pos_x, pos_z, frame_us, output ready);
endinterface

interface wse_speed_if;
  import wse_pkg::*;
  logic             valid;
  logic             ready;
  logic [SPD_W-1:0] speed_smooth;
  logic [SPD_W-1:0] speed_quick;
  logic             is_moving;
  logic             sample_taken;
  modport source (output valid, speed_smooth, speed_quick, is_moving, sample_taken,
                  input ready);
  modport sink (input valid, speed_smooth, speed_quick, is_moving, sample_taken,
                output ready);
endinterface

// ===== hw/rtl/wse_sqrt.sv =====
module wse_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wse_pkg::POS_W-1:0]  ax,
  input  logic [wse_pkg::POS_W-1:0]  az,
  output logic                       done,
  output logic [wse_pkg::ROOT_W-1:0] root
);
  import wse_pkg::*;

  sq_state_t        sq_state, sq_state_next;
  logic [4:0]       cnt;
  logic [POS_W-1:0] opx, opz, mx, mz;
  logic [SQ_W-1:0]  acc;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] rem_sh, trial;
  logic             ge;

  assign rem_sh = {rem, acc[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    sq_state_next = sq_state;
    case (sq_state)
      SQ_IDLE: if (start) sq_state_next = SQ_MUL;
      SQ_MUL:  if (cnt == 5'(POS_W - 1)) sq_state_next = SQ_ROOT;
      SQ_ROOT: if (cnt == 5'(ROOT_W - 1)) sq_state_next = SQ_IDLE;
      default: sq_state_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    case (sq_state)
      SQ_ROOT: done = (cnt == 5'(ROOT_W - 1));
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_state <= SQ_IDLE;
    end else begin
      sq_state <= sq_state_next;
    end
  end

  // sum of squares msb first, then two radicand bits per step
  always_ff @(posedge clk) begin
    case (sq_state)
      SQ_IDLE: begin
        cnt <= '0;
        acc <= '0;
        opx <= ax;
        opz <= az;
        mx  <= ax;
        mz  <= az;
      end
      SQ_MUL: begin
        acc <= (acc << 1)
             + (mx[POS_W-1] ? {{(SQ_W-POS_W){1'b0}}, opx} : '0)
             + (mz[POS_W-1] ? {{(SQ_W-POS_W){1'b0}}, opz} : '0);
        mx  <= mx << 1;
        mz  <= mz << 1;
        rem  <= '0;
        root <= '0;
        cnt <= (cnt == 5'(POS_W - 1)) ? '0 : cnt + 5'd1;
      end
      SQ_ROOT: begin
        acc <= acc << 2;
        if (ge) begin
          rem  <= REM_W'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// ===== hw/rtl/wse_div.sv =====
module wse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wse_pkg::WDIST_W-1:0] wdist,
  input  logic [wse_pkg::WTIME_W-1:0] wtime,
  output logic                        done,
  output logic [wse_pkg::SPD_W-1:0]   speed
);
  import wse_pkg::*;

  dv_state_t          dv_state, dv_state_next;
  logic [5:0]         cnt;
  logic [SCALE_W-1:0] kreg;
  logic [WDIST_W-1:0] dreg;
  logic [WTIME_W-1:0] den;
  logic [NUM_W-1:0]   num;
  logic [WTIME_W-1:0] rem;
  logic [WTIME_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign speed  = (|num[NUM_W-1:SPD_W]) ? '1 : num[SPD_W-1:0];

  always_comb begin
    dv_state_next = dv_state;
    case (dv_state)
      DV_IDLE:  if (start) dv_state_next = DV_SCALE;
      DV_SCALE: if (cnt == 6'(SCALE_W - 1)) dv_state_next = DV_DIV;
      DV_DIV:   if (cnt == 6'(NUM_W - 1)) dv_state_next = DV_IDLE;
      default:  dv_state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    case (dv_state)
      DV_DIV:  done = (cnt == 6'(NUM_W - 1));
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state <= DV_IDLE;
    end else begin
      dv_state <= dv_state_next;
    end
  end

  // distance times 1e6 plus half the time, then restoring division
  always_ff @(posedge clk) begin
    case (dv_state)
      DV_IDLE: begin
        cnt  <= '0;
        num  <= '0;
        kreg <= US_PER_S;
        dreg <= wdist;
        den  <= wtime;
      end
      DV_SCALE: begin
        num <= (num << 1)
             + (kreg[SCALE_W-1] ? {{(NUM_W-WDIST_W){1'b0}}, dreg} : '0)
             + ((cnt == 6'(SCALE_W - 1)) ? {{(NUM_W-WTIME_W+1){1'b0}}, den[WTIME_W-1:1]}
                                          : '0);
        kreg <= kreg << 1;
        rem  <= '0;
        cnt  <= (cnt == 6'(SCALE_W - 1)) ? '0 : cnt + 6'd1;
      end
      DV_DIV: begin
        rem <= ge ? WTIME_W'(rem_sh - {1'b0, den}) : rem_sh[WTIME_W-1:0];
        num <= {num[NUM_W-2:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// ===== hw/rtl/windowed_speed_estimator_unit.sv =====
// a request takes the divide and gain update path only when its step is valid and closes a window
// a new request is taken only after the result of the last one is stored
// the bit-serial square-sum and root and the scaled divide take most of the time of a request
// a waiting result that has not been taken blocks the next request
// synchronous active-high reset clears position, window, speeds, flag and registers
`include "assert_macros.svh"

module windowed_speed_estimator_unit (
  input  logic                       clk,
  input  logic                       rst,
  wse_frame_if.sink                  frame,
  wse_speed_if.source                speed,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wse_pkg::ADDR_W-1:0] paddr,
  input  logic [wse_pkg::DATA_W-1:0] pwdata,
  output logic [wse_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import wse_pkg::*;

  wse_state_t state, state_next;

  logic [WIN_W-1:0]   window_us;
  logic [HITCH_W-1:0] hitch_limit_us;
  logic [JUMP_W-1:0]  jump_limit_mm;
  logic [SPD_W-1:0]   move_on_mm_s;
  logic [SPD_W-1:0]   move_off_mm_s;

  logic signed [POS_W-1:0] cur_x, cur_z, prev_x, prev_z;
  logic [FT_W-1:0]         cur_ft;
  logic                    have_prev;
  logic [WDIST_W-1:0]      window_dist;
  logic [WTIME_W-1:0]      window_time;
  logic [SPD_W-1:0]        ema_slow, ema_fast;
  logic                    moving_flag;
  logic                    sample;
  logic [GIDX_W-1:0]       gidx;

  logic             up_s, up_f;
  logic [SPD_W-1:0] diff_s, diff_f, gs, gf;
  logic [31:0]      prod_s, prod_f, rnd_s, rnd_f;
  logic [3:0]       cnt;

  logic signed [POS_W:0] dx, dz;
  logic [POS_W-1:0]      ax, az;
  logic                  sq_start, sq_done;
  logic [ROOT_W-1:0]     step_len;
  logic                  dv_start, dv_done;
  logic [SPD_W-1:0]      inst;

  logic [WDIST_W:0]     sum_d;
  logic [WTIME_W:0]     sum_t;
  logic [WDIST_W-1:0]   sat_d;
  logic [WTIME_W-1:0]   sat_t;
  logic                 step_ok, close;
  logic [WTIME_W:0]     idx_n;
  logic [M_W+RECIP_W-1:0] idx_prod;
  logic [GIDX_W-1:0]    idx;

  logic out_free, out_load, cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us      <= WINDOW_US_RST;
      hitch_limit_us <= HITCH_RST;
      jump_limit_mm  <= JUMP_RST;
      move_on_mm_s   <= MOVE_ON_RST;
      move_off_mm_s  <= MOVE_OFF_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_WINDOW_US:      window_us      <= pwdata[WIN_W-1:0];
        REG_HITCH_LIMIT_US: hitch_limit_us <= pwdata[HITCH_W-1:0];
        REG_JUMP_LIMIT_MM:  jump_limit_mm  <= pwdata[JUMP_W-1:0];
        REG_MOVE_ON_MM_S:   move_on_mm_s   <= pwdata[SPD_W-1:0];
        REG_MOVE_OFF_MM_S:  move_off_mm_s  <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_WINDOW_US:      prdata = DATA_W'(window_us);
      REG_HITCH_LIMIT_US: prdata = DATA_W'(hitch_limit_us);
      REG_JUMP_LIMIT_MM:  prdata = DATA_W'(jump_limit_mm);
      REG_MOVE_ON_MM_S:   prdata = DATA_W'(move_on_mm_s);
      REG_MOVE_OFF_MM_S:  prdata = DATA_W'(move_off_mm_s);
      default:            prdata = '0;
    endcase
  end

  // step length
  assign dx = {cur_x[POS_W-1], cur_x} - {prev_x[POS_W-1], prev_x};
  assign dz = {cur_z[POS_W-1], cur_z} - {prev_z[POS_W-1], prev_z};
  assign ax = !have_prev ? '0 : (dx[POS_W] ? POS_W'(-dx) : POS_W'(dx));
  assign az = !have_prev ? '0 : (dz[POS_W] ? POS_W'(-dz) : POS_W'(dz));

  wse_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .ax    (ax),
    .az    (az),
    .done  (sq_done),
    .root  (step_len)
  );

  wse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .wdist (window_dist),
    .wtime (window_time),
    .done  (dv_done),
    .speed (inst)
  );

  // window accumulation
  assign sum_d   = {1'b0, window_dist} + {{(WDIST_W-ROOT_W+1){1'b0}}, step_len};
  assign sum_t   = {1'b0, window_time} + {{(WTIME_W-FT_W+1){1'b0}}, cur_ft};
  assign sat_d   = sum_d[WDIST_W] ? '1 : sum_d[WDIST_W-1:0];
  assign sat_t   = sum_t[WTIME_W] ? '1 : sum_t[WTIME_W-1:0];
  assign step_ok = (cur_ft != '0) && (cur_ft < hitch_limit_us)
                && (step_len < {{(ROOT_W-JUMP_W){1'b0}}, jump_limit_mm});
  assign close   = sat_t >= {{(WTIME_W-WIN_W){1'b0}}, window_us};

  // gain index, rounded to 10 ms and clamped to the last entry
  assign idx_n    = {1'b0, window_time} + IDX_HALF;
  assign idx_prod = idx_n[M_W+3:4] * RECIP_M;
  assign idx      = (idx_n >= IDX_LIMIT) ? GIDX_W'(GAIN_TABLE_ENTRIES - 1)
                                          : idx_prod[RECIP_SH +: GIDX_W];

  assign rnd_s = prod_s + 32'h8000;
  assign rnd_f = prod_f + 32'h8000;

  assign out_free = !speed.valid || speed.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (frame.valid) state_next = ST_SQGO;
      ST_SQGO:  state_next = ST_SQ;
      ST_SQ:    if (sq_done) state_next = ST_ACC;
      ST_ACC:   state_next = (step_ok && close) ? ST_DVGO : ST_DONE;
      ST_DVGO:  state_next = ST_DV;
      ST_DV:    if (dv_done) state_next = ST_EMA0;
      ST_EMA0:  state_next = ST_MUL;
      ST_MUL:   if (cnt == 4'hF) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_FLAG;
      ST_FLAG:  state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    frame.ready = 1'b0;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: frame.ready = 1'b1;
      ST_SQGO: sq_start    = 1'b1;
      ST_DVGO: dv_start    = 1'b1;
      ST_DONE: out_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_z      <= '0;
      have_prev   <= 1'b0;
      window_dist <= '0;
      window_time <= '0;
      ema_slow    <= '0;
      ema_fast    <= '0;
      moving_flag <= 1'b0;
    end else begin
      case (state)
        ST_SQGO: begin
          prev_x    <= cur_x;
          prev_z    <= cur_z;
          have_prev <= 1'b1;
        end
        ST_ACC: begin
          if (step_ok) begin
            window_dist <= sat_d;
            window_time <= sat_t;
          end else begin
            window_dist <= '0;
            window_time <= '0;
          end
        end
        ST_APPLY: begin
          ema_slow <= up_s ? ema_slow + rnd_s[31:16] : ema_slow - rnd_s[31:16];
          ema_fast <= up_f ? ema_fast + rnd_f[31:16] : ema_fast - rnd_f[31:16];
        end
        ST_FLAG: begin
          if (ema_fast > move_on_mm_s) begin
            moving_flag <= 1'b1;
          end else if (ema_fast < move_off_mm_s) begin
            moving_flag <= 1'b0;
          end
          window_dist <= '0;
          window_time <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_x  <= frame.pos_x;
        cur_z  <= frame.pos_z;
        cur_ft <= frame.frame_us;
      end
      ST_ACC: sample <= 1'b0;
      ST_DVGO: gidx <= idx;
      ST_EMA0: begin
        up_s   <= inst >= ema_slow;
        up_f   <= inst >= ema_fast;
        diff_s <= (inst >= ema_slow) ? inst - ema_slow : ema_slow - inst;
        diff_f <= (inst >= ema_fast) ? inst - ema_fast : ema_fast - inst;
        gs     <= GAIN_SLOW[gidx];
        gf     <= GAIN_FAST[gidx];
        prod_s <= '0;
        prod_f <= '0;
        cnt    <= '0;
      end
      ST_MUL: begin
        prod_s <= (prod_s << 1) + (gs[SPD_W-1] ? {16'd0, diff_s} : 32'd0);
        prod_f <= (prod_f << 1) + (gf[SPD_W-1] ? {16'd0, diff_f} : 32'd0);
        gs     <= gs << 1;
        gf     <= gf << 1;
        cnt    <= cnt + 4'd1;
      end
      ST_FLAG: sample <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed.valid <= 1'b0;
    end else if (out_load) begin
      speed.valid <= 1'b1;
    end else if (speed.ready) begin
      speed.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      speed.speed_smooth <= ema_slow;
      speed.speed_quick  <= ema_fast;
      speed.is_moving    <= moving_flag;
      speed.sample_taken <= sample;
    end
  end

  `WSE_ASSERT_NXT(a_accept_blocks, clk, rst, frame.valid && frame.ready, !frame.ready)
  `WSE_ASSERT_NXT(a_result_loaded, clk, rst, out_load, speed.valid)
  `WSE_ASSERT_IMP(a_div_in_state, clk, rst, dv_done, state == ST_DV)

endmodule
